### hw/rtl/tree_lca_binary_lifting_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the lowest common ancestor block.
// ----------------------------------------------------------------------------
`ifndef TREE_LCA_BINARY_LIFTING_MACROS_SVH
`define TREE_LCA_BINARY_LIFTING_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCA_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hw/rtl/lca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCA package
// Operation codes and beat types shared by the sequencer and the top level.
// ----------------------------------------------------------------------------
package lca_pkg;

    localparam int NODE_W = 10;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [NODE_W-1:0] first;
        logic [NODE_W-1:0] second;
    } t_item;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              error;
    } t_result;

endpackage

### hw/rtl/lca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCA dual-read RAM
// One write port and two read ports, with registered read data.
// ----------------------------------------------------------------------------
module lca_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(P_DEPTH)-1:0] i_wr_addr,
    input  logic [P_WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(P_DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(P_DEPTH)-1:0] i_rd_addr_b,
    output logic [P_WIDTH-1:0]         o_rd_data_a,
    output logic [P_WIDTH-1:0]         o_rd_data_b
);

    logic [P_WIDTH-1:0] mem [P_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data_a <= mem[i_rd_addr_a];
        o_rd_data_b <= mem[i_rd_addr_b];
    end

endmodule

### hw/rtl/lca_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCA sequencer
// Owns the node information and ancestor tables and steps one beat at a
// time through loading a node or answering a common ancestor query.
// ----------------------------------------------------------------------------
`include "tree_lca_binary_lifting_macros.svh"

module lca_seq import lca_pkg::*; #(
    parameter int MAX_NODES   = 1024,
    parameter int LIFT_LEVELS = 10
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_item_ready,
    output logic    o_done,
    output t_result o_result,
    input  logic    i_slot_free
);

    localparam int DEPTH_N   = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
    localparam int AW        = $clog2(DEPTH_N);
    localparam int LW        = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int ANC_DEPTH = 1 << (LW + AW);
    localparam int INFO_W    = AW + 1;

    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH_N - 1);
    localparam logic [LW-1:0] LVL_TOP  = LW'(LIFT_LEVELS - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_FILL_RD,
        S_FILL_WR,
        S_LIFT,
        S_LIFT_WT,
        S_TOP_RD,
        S_TOP_WT,
        S_DESC_RD,
        S_DESC_WT,
        S_LAST_RD,
        S_LAST_WT,
        S_DONE
    } t_state;

    t_state          r_state;
    t_op             r_op;
    logic [AW-1:0]   r_clr;
    logic [AW-1:0]   r_a;
    logic [AW-1:0]   r_b;
    logic [AW-1:0]   r_diff;
    logic [AW-1:0]   r_res;
    logic [LW-1:0]   r_lvl;
    logic            r_same;
    logic            r_rng_a;
    logic            r_rng_b;
    logic            r_err;

    logic              info_we;
    logic [AW-1:0]     info_wa;
    logic [INFO_W-1:0] info_wd;
    logic [INFO_W-1:0] info_rd_a;
    logic [INFO_W-1:0] info_rd_b;

    logic              anc_we;
    logic [LW+AW-1:0]  anc_wa;
    logic [AW-1:0]     anc_wd;
    logic [LW+AW-1:0]  anc_ra_a;
    logic [LW+AW-1:0]  anc_ra_b;
    logic [AW-1:0]     anc_rd_a;
    logic [AW-1:0]     anc_rd_b;

    logic          w_accept;
    logic          w_la;
    logic          w_lb;
    logic          w_load_err;
    logic          w_swap;
    logic [AW-1:0] w_hi;
    logic [AW-1:0] w_lo;
    logic [AW-1:0] w_diff;
    logic [AW-1:0] w_new_depth;
    logic [LW-1:0] w_k;
    logic [LW-1:0] w_lvl_prev;
    logic [AW-1:0] w_step;
    logic          w_pair_differs;
    logic          w_both_roots;

    function automatic logic [LW-1:0] f_lift_level(input logic [AW-1:0] diff);
        logic [LW-1:0] k;
        k = '0;
        for (int i = 0; i < AW; i++) begin
            if (diff[i]) begin
                k = (i < LIFT_LEVELS) ? LW'(i) : LVL_TOP;
            end
        end
        return k;
    endfunction

    lca_ram #(
        .P_WIDTH (INFO_W),
        .P_DEPTH (DEPTH_N)
    ) u_info_ram (
        .i_clk       (i_clk),
        .i_wr_en     (info_we),
        .i_wr_addr   (info_wa),
        .i_wr_data   (info_wd),
        .i_rd_addr_a (i_item.first[AW-1:0]),
        .i_rd_addr_b (i_item.second[AW-1:0]),
        .o_rd_data_a (info_rd_a),
        .o_rd_data_b (info_rd_b)
    );

    lca_ram #(
        .P_WIDTH (AW),
        .P_DEPTH (ANC_DEPTH)
    ) u_anc_ram (
        .i_clk       (i_clk),
        .i_wr_en     (anc_we),
        .i_wr_addr   (anc_wa),
        .i_wr_data   (anc_wd),
        .i_rd_addr_a (anc_ra_a),
        .i_rd_addr_b (anc_ra_b),
        .o_rd_data_a (anc_rd_a),
        .o_rd_data_b (anc_rd_b)
    );

    assign o_item_ready = (r_state == S_IDLE);
    assign w_accept     = i_item_valid && o_item_ready;
    assign o_done       = (r_state == S_DONE) && i_slot_free;

    assign o_result.ancestor = NODE_W'(r_res);
    assign o_result.error    = r_err;

    assign w_la       = r_rng_a && info_rd_a[AW];
    assign w_lb       = r_rng_b && info_rd_b[AW];
    assign w_load_err = (!w_lb && !r_same) || !r_rng_a || info_rd_a[AW];

    // Single subtractor for the depth difference: larger minus smaller.
    assign w_swap      = info_rd_a[AW-1:0] < info_rd_b[AW-1:0];
    assign w_hi        = w_swap ? info_rd_b[AW-1:0] : info_rd_a[AW-1:0];
    assign w_lo        = w_swap ? info_rd_a[AW-1:0] : info_rd_b[AW-1:0];
    assign w_diff      = w_hi - w_lo;
    assign w_new_depth = r_same ? '0 : info_rd_b[AW-1:0] + AW'(1);

    assign w_k        = f_lift_level(r_diff);
    assign w_step     = AW'(1) << w_k;
    assign w_lvl_prev = r_lvl - LW'(1);

    assign w_pair_differs = (anc_rd_a != anc_rd_b);
    assign w_both_roots   = (anc_rd_a == r_a) && (anc_rd_b == r_b);

    always_comb begin
        info_we = 1'b0;
        info_wa = r_a;
        info_wd = {1'b1, w_new_depth};
        if (r_state == S_CLEAR) begin
            info_we = 1'b1;
            info_wa = r_clr;
            info_wd = '0;
        end else if ((r_state == S_CHECK) && (r_op == OP_LOAD) && !w_load_err) begin
            info_we = 1'b1;
        end

        anc_we = 1'b0;
        anc_wa = {LW'(0), r_a};
        anc_wd = r_b;
        if ((r_state == S_CHECK) && (r_op == OP_LOAD) && !w_load_err) begin
            anc_we = 1'b1;
        end else if (r_state == S_FILL_WR) begin
            anc_we = 1'b1;
            anc_wa = {r_lvl, r_a};
            anc_wd = anc_rd_a;
        end

        anc_ra_a = {r_lvl, r_a};
        anc_ra_b = {r_lvl, r_b};
        unique case (r_state)
            S_FILL_RD: begin
                anc_ra_a = {w_lvl_prev, r_b};
            end
            S_LIFT: begin
                anc_ra_a = {w_k, r_a};
            end
            S_TOP_RD: begin
                anc_ra_a = {LVL_TOP, r_a};
                anc_ra_b = {LVL_TOP, r_b};
            end
            S_LAST_RD: begin
                anc_ra_a = {LW'(0), r_a};
                anc_ra_b = {LW'(0), r_b};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_op    <= i_item.op;
                        r_same  <= (i_item.first == i_item.second);
                        r_rng_a <= {{(32-NODE_W){1'b0}}, i_item.first} < 32'(MAX_NODES);
                        r_rng_b <= {{(32-NODE_W){1'b0}}, i_item.second} < 32'(MAX_NODES);
                        r_a     <= i_item.first[AW-1:0];
                        r_b     <= i_item.second[AW-1:0];
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_op == OP_LOAD) begin
                        r_res <= '0;
                        if (w_load_err) begin
                            r_err   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_err   <= 1'b0;
                            r_lvl   <= LW'(1);
                            r_state <= (LIFT_LEVELS > 1) ? S_FILL_RD : S_DONE;
                        end
                    end else if (!w_la || !w_lb) begin
                        r_res   <= '0;
                        r_err   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_err <= 1'b0;
                        if (w_swap) begin
                            r_a <= r_b;
                            r_b <= r_a;
                        end
                        r_diff  <= w_diff;
                        r_state <= S_LIFT;
                    end
                end
                S_FILL_RD: begin
                    r_state <= S_FILL_WR;
                end
                S_FILL_WR: begin
                    r_b <= anc_rd_a;
                    if (r_lvl == LVL_TOP) begin
                        r_state <= S_DONE;
                    end else begin
                        r_lvl   <= r_lvl + LW'(1);
                        r_state <= S_FILL_RD;
                    end
                end
                S_LIFT: begin
                    if (r_diff == '0) begin
                        if (r_a == r_b) begin
                            r_res   <= r_a;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_TOP_RD;
                        end
                    end else begin
                        r_diff  <= r_diff - w_step;
                        r_state <= S_LIFT_WT;
                    end
                end
                S_LIFT_WT: begin
                    r_a     <= anc_rd_a;
                    r_state <= S_LIFT;
                end
                S_TOP_RD: begin
                    r_state <= S_TOP_WT;
                end
                S_TOP_WT: begin
                    if (w_pair_differs && !w_both_roots) begin
                        r_a     <= anc_rd_a;
                        r_b     <= anc_rd_b;
                        r_state <= S_TOP_RD;
                    end else if (LIFT_LEVELS > 1) begin
                        r_lvl   <= LW'(LIFT_LEVELS - 2);
                        r_state <= S_DESC_RD;
                    end else begin
                        r_state <= S_LAST_RD;
                    end
                end
                S_DESC_RD: begin
                    r_state <= S_DESC_WT;
                end
                S_DESC_WT: begin
                    if (w_pair_differs) begin
                        r_a <= anc_rd_a;
                        r_b <= anc_rd_b;
                    end
                    if (r_lvl == '0) begin
                        r_state <= S_LAST_RD;
                    end else begin
                        r_lvl   <= r_lvl - LW'(1);
                        r_state <= S_DESC_RD;
                    end
                end
                S_LAST_RD: begin
                    if (r_a == r_b) begin
                        r_res   <= r_a;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_LAST_WT;
                    end
                end
                S_LAST_WT: begin
                    if (!w_pair_differs) begin
                        r_res <= anc_rd_a;
                        r_err <= 1'b0;
                    end else begin
                        r_res <= '0;
                        r_err <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `LCA_ASSERT_NEXT(a_accept_to_check, w_accept, r_state == S_CHECK, "Accepted beat did not reach the check step.")
    `LCA_ASSERT_NEXT(a_lift_shrinks, (r_state == S_LIFT) && (r_diff != '0), r_diff < $past(r_diff), "Depth difference did not shrink while lifting.")
    `LCA_ASSERT_NOW(a_fill_level, (r_state == S_FILL_RD) || (r_state == S_FILL_WR), (r_lvl != '0) && (r_lvl <= LVL_TOP), "Table fill level out of range.")
    `LCA_ASSERT_NOW(a_load_result_zero, o_done && (r_op == OP_LOAD), o_result.ancestor == '0, "Load beat returned a nonzero ancestor.")

endmodule

### hw/rtl/tree_lca_binary_lifting.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree lowest common ancestor, binary lifting
// Loads a rooted forest node by node into an ancestor table and answers
// lowest common ancestor queries, with one result beat per input beat.
//
//   Channel  Handshake                 Payload
//   input    i_in_valid / o_in_ready   i_operation, i_first_node, i_second_node
//   output   o_out_valid / i_out_ready o_common_ancestor, o_error
//
// A load fills the ancestor table level by level, each level a read, then a write.
// A query lifts the deeper node, takes top-level jumps, descends the levels and
// checks the parents; each step reads the two-read ancestor memory and waits for it.
// After reset, a pass clearing min(MAX_NODES, 1024) node entries holds o_in_ready low.
// A result waits in the output register; the next beat is accepted meanwhile,
// and the sequencer holds its finished result until that register is free.
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting import lca_pkg::*; #(
    parameter int MAX_NODES   = 1024,
    parameter int LIFT_LEVELS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_operation,
    input  logic [NODE_W-1:0] i_first_node,
    input  logic [NODE_W-1:0] i_second_node,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [NODE_W-1:0] o_common_ancestor,
    output logic              o_error
);

    t_item   w_item;
    t_result w_result;
    logic    w_done;
    logic    w_slot_free;
    logic    r_out_valid;
    t_result r_out;

    assign w_item.op     = t_op'(i_operation);
    assign w_item.first  = i_first_node;
    assign w_item.second = i_second_node;

    assign w_slot_free = !r_out_valid || i_out_ready;

    lca_seq #(
        .MAX_NODES   (MAX_NODES),
        .LIFT_LEVELS (LIFT_LEVELS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_in_valid),
        .i_item       (w_item),
        .o_item_ready (o_in_ready),
        .o_done       (w_done),
        .o_result     (w_result),
        .i_slot_free  (w_slot_free)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_common_ancestor = r_out.ancestor;
    assign o_error           = r_out.error;

endmodule

### dv/tree_lca_binary_lifting_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree lowest common ancestor testbench
// Builds forests through load beats and checks every load and query result
// against a behavioral ancestor-table predictor kept inside the bench. Covers
// directed corner cases, a deep random build, a mixed phase, output back
// pressure that fills the block, a drain pause, and a final streaming phase.
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting_tb import lca_pkg::*; ();

    localparam int MAX_NODES      = 1024;
    localparam int LIFT_LEVELS    = 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 100;
    localparam int TARGET_DEPTH   = 600;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_operation;
    logic [NODE_W-1:0] i_first_node;
    logic [NODE_W-1:0] i_second_node;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [NODE_W-1:0] o_common_ancestor;
    logic              o_error;

    logic [NODE_W-1:0] anc_tab [LIFT_LEVELS][MAX_NODES];
    int                node_dep [MAX_NODES];
    bit                node_in_tree [MAX_NODES];
    int                tree_nodes [$];
    int                deep_tip;
    t_result           pending_answers [$];
    int                mismatch_count;
    int                quiet_cycles;
    bit                stream_mode;
    bit                holdoff_req;
    t_result           due;

    tree_lca_binary_lifting #(
        .MAX_NODES   (MAX_NODES),
        .LIFT_LEVELS (LIFT_LEVELS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_operation       (i_operation),
        .i_first_node      (i_first_node),
        .i_second_node     (i_second_node),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_common_ancestor (o_common_ancestor),
        .o_error           (o_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result lca_lookup(input int first, input int second);
        t_result res;
        int      a;
        int      b;
        int      tmp;
        int      diff;
        int      k;
        int      na;
        int      nb;
        res = '0;
        a = first;
        b = second;
        if (!node_in_tree[a] || !node_in_tree[b]) begin
            res.error = 1'b1;
            return res;
        end
        if (node_dep[a] < node_dep[b]) begin
            tmp = a;
            a = b;
            b = tmp;
        end
        diff = node_dep[a] - node_dep[b];
        while (diff != 0) begin
            k = LIFT_LEVELS - 1;
            while (k > 0 && (1 << k) > diff) k--;
            a = int'(anc_tab[k][a]);
            diff -= 1 << k;
        end
        if (a == b) begin
            res.ancestor = NODE_W'(a);
            return res;
        end
        while (anc_tab[LIFT_LEVELS-1][a] != anc_tab[LIFT_LEVELS-1][b]) begin
            na = int'(anc_tab[LIFT_LEVELS-1][a]);
            nb = int'(anc_tab[LIFT_LEVELS-1][b]);
            if (na == a && nb == b) break;
            a = na;
            b = nb;
        end
        for (k = LIFT_LEVELS - 2; k >= 0; k--) begin
            if (anc_tab[k][a] != anc_tab[k][b]) begin
                a = int'(anc_tab[k][a]);
                b = int'(anc_tab[k][b]);
            end
        end
        if (a == b) begin
            res.ancestor = NODE_W'(a);
        end else if (anc_tab[0][a] == anc_tab[0][b]) begin
            res.ancestor = anc_tab[0][a];
        end else begin
            res.error = 1'b1;
        end
        return res;
    endfunction

    // Loads update the tree copy here, so the random generator always sees
    // the forest as the block holds it after the beat.
    function automatic t_result predict_tree_item(input t_op op, input int node,
                                                  input int other);
        t_result res;
        int      k;
        res = '0;
        if (op == OP_QUERY) return lca_lookup(node, other);
        if ((!node_in_tree[other] && other != node) || node_in_tree[node]) begin
            res.error = 1'b1;
            return res;
        end
        if (other == node) begin
            node_dep[node] = 0;
            for (k = 0; k < LIFT_LEVELS; k++) anc_tab[k][node] = NODE_W'(node);
        end else begin
            node_dep[node] = node_dep[other] + 1;
            anc_tab[0][node] = NODE_W'(other);
            for (k = 1; k < LIFT_LEVELS; k++)
                anc_tab[k][node] = anc_tab[k-1][anc_tab[k-1][node]];
        end
        node_in_tree[node] = 1'b1;
        tree_nodes.insert(tree_nodes.size(), node);
        if (deep_tip < 0 || node_dep[node] > node_dep[deep_tip]) deep_tip = node;
        return res;
    endfunction

    task automatic send_item(input t_op op, input int first, input int second);
        @(negedge i_clk);
        if (!stream_mode && $urandom_range(3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_first_node  <= NODE_W'(first);
        i_second_node <= NODE_W'(second);
        do @(posedge i_clk); while (!o_in_ready);
        pending_answers.insert(pending_answers.size(), predict_tree_item(op, first, second));
    endtask

    task automatic idle_input_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    function automatic int pick_free_node();
        int node;
        do node = $urandom_range(MAX_NODES - 1); while (node_in_tree[node]);
        return node;
    endfunction

    function automatic int pick_tree_node();
        return tree_nodes[$urandom_range(tree_nodes.size() - 1)];
    endfunction

    task automatic send_random_load();
        int roll;
        roll = $urandom_range(99);
        if (tree_nodes.size() >= MAX_NODES || roll < 4) begin
            send_item(OP_LOAD, $urandom_range(MAX_NODES - 1), $urandom_range(MAX_NODES - 1));
        end else if (tree_nodes.size() == 0 || roll < 7) begin
            roll = pick_free_node();
            send_item(OP_LOAD, roll, roll);
        end else if (roll < 17) begin
            send_item(OP_LOAD, pick_free_node(), pick_tree_node());
        end else begin
            send_item(OP_LOAD, pick_free_node(), deep_tip);
        end
    endtask

    task automatic send_random_query();
        int roll;
        roll = $urandom_range(99);
        if (tree_nodes.size() == 0 || roll < 8) begin
            send_item(OP_QUERY, $urandom_range(MAX_NODES - 1), $urandom_range(MAX_NODES - 1));
        end else if (roll < 30) begin
            send_item(OP_QUERY, deep_tip, pick_tree_node());
        end else begin
            send_item(OP_QUERY, pick_tree_node(), pick_tree_node());
        end
    endtask

    task automatic send_random_mix(input int count, input int load_pct);
        repeat (count) begin
            if ($urandom_range(99) < load_pct) send_random_load();
            else send_random_query();
        end
    endtask

    task automatic test_directed_corners();
        send_item(OP_QUERY, 0, 0);
        send_item(OP_LOAD, 5, 7);
        send_item(OP_LOAD, 1023, 1023);
        send_item(OP_LOAD, 0, 0);
        send_item(OP_LOAD, 1023, 1023);
        send_item(OP_LOAD, 682, 1023);
        send_item(OP_LOAD, 341, 682);
        send_item(OP_LOAD, 512, 341);
        send_item(OP_LOAD, 1, 682);
        send_item(OP_QUERY, 512, 1);
        send_item(OP_QUERY, 1, 512);
        send_item(OP_QUERY, 512, 512);
        send_item(OP_QUERY, 512, 1023);
        send_item(OP_QUERY, 1023, 0);
        send_item(OP_QUERY, 341, 7);
        send_item(OP_LOAD, 2, 0);
        send_item(OP_LOAD, 3, 2);
        send_item(OP_QUERY, 3, 0);
        send_item(OP_LOAD, 341, 0);
        send_item(OP_QUERY, 1023, 1023);
        send_item(OP_QUERY, 3, 512);
    endtask

    task automatic test_deep_build();
        int sent;
        sent = 0;
        while (node_dep[deep_tip] < TARGET_DEPTH && sent < 800) begin
            send_random_mix(1, 93);
            sent++;
        end
    endtask

    task automatic test_output_holdoff();
        holdoff_req = 1'b1;
        send_random_mix(8, 20);
    endtask

    task automatic test_mixed_forest();
        send_random_mix(60, 40);
    endtask

    task automatic test_drain_pause();
        send_random_mix(20, 30);
        idle_input_until_drained();
    endtask

    task automatic test_streaming();
        stream_mode = 1'b1;
        send_random_mix(60, 30);
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES - 1) @(negedge i_clk);
                holdoff_req = 1'b0;
            end else if (!stream_mode && $urandom_range(5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_answers.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with nothing expected: ancestor %0d, error %0b",
                         $time, o_common_ancestor, o_error);
            end else begin
                due = pending_answers.pop_front();
                if (o_common_ancestor !== due.ancestor) begin
                    mismatch_count++;
                    $display("%0t: common_ancestor mismatch: expected %0d, actual %0d",
                             $time, due.ancestor, o_common_ancestor);
                end
                if (o_error !== due.error) begin
                    mismatch_count++;
                    $display("%0t: error mismatch: expected %0b, actual %0b",
                             $time, due.error, o_error);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_operation    = OP_LOAD;
        i_first_node   = '0;
        i_second_node  = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        stream_mode    = 1'b0;
        holdoff_req    = 1'b0;
        deep_tip       = -1;
        for (int n = 0; n < MAX_NODES; n++) begin
            node_in_tree[n] = 1'b0;
            node_dep[n]     = 0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_deep_build();
        test_output_holdoff();
        test_mixed_forest();
        test_drain_pause();
        test_streaming();

        idle_input_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
